FILE: rtl/core/bts_pkg.sv
package bts_pkg;

	// Configuration port
	localparam int CFG_W     = 11;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

	// Request opcodes
	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// Parameter defaults
	localparam int DEF_MAX_TEXELS      = 65536;
	localparam int DEF_COORD_FRAC_BITS = 16;

	// Fixed widths
	localparam int TEXEL_W    = 24;
	localparam int CHAN_W     = 8;
	localparam int NUM_CHAN   = 3;
	localparam int OUT_W      = 16;
	localparam int ADDR_IN_W  = 16;
	localparam int COORD_W    = 24;
	localparam int NUM_TAPS   = 4;
	// y*w+x with both sizes held in CFG_W bits stays below 2^22
	localparam int RAW_ADDR_W = 22;
	// wide enough to hold the largest texel count
	localparam int TEX_LIM_W  = 21;
	localparam int NUM_STAGES = 8;

	// Fallback colour (0.1, 0.1, 0.2) in output units
	localparam logic [OUT_W-1:0] FALLBACK_RG = 16'd6528;
	localparam logic [OUT_W-1:0] FALLBACK_B  = 16'd13056;

	typedef struct packed {
		logic                        opcode;
		logic [ADDR_IN_W-1:0]        texel_address;
		logic [CHAN_W-1:0]           write_red;
		logic [CHAN_W-1:0]           write_green;
		logic [CHAN_W-1:0]           write_blue;
		logic signed [COORD_W-1:0]   coord_u;
		logic signed [COORD_W-1:0]   coord_v;
	} req_t;

	typedef struct packed {
		logic [OUT_W-1:0] out_red;
		logic [OUT_W-1:0] out_green;
		logic [OUT_W-1:0] out_blue;
		logic             used_fallback;
	} rsp_t;

	// Per-stage load strobes, MSB is the last stage
	typedef struct packed {
		logic s8;
		logic s7;
		logic s6;
		logic s5;
		logic s4;
		logic s3;
		logic s2;
		logic s1;
	} stage_en_t;

endpackage

FILE: rtl/core/bts_texel_ram.sv
module bts_texel_ram
	import bts_pkg::*;
#(
	parameter int DEPTH = DEF_MAX_TEXELS,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  logic [TEXEL_W-1:0] wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr0,
	input  logic [AW-1:0]      raddr1,
	output logic [TEXEL_W-1:0] rdata0,
	output logic [TEXEL_W-1:0] rdata1
);

	logic [TEXEL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		// hold read data while the stage is stalled
		if (re) begin
			rdata0 <= mem[raddr0];
			rdata1 <= mem[raddr1];
		end
	end

endmodule

FILE: rtl/core/bts_coord.sv
module bts_coord
	import bts_pkg::*;
#(
	parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
	input  logic                       clk,
	input  stage_en_t                  en,
	input  req_t                       req,
	input  logic [CFG_W-1:0]           tex_w,
	input  logic [CFG_W-1:0]           tex_h,
	output logic                       op_s2,
	output logic [ADDR_IN_W-1:0]       waddr_s2,
	output logic [TEXEL_W-1:0]         wdata_s2,
	output logic                       fb_s2,
	output logic [COORD_FRAC_BITS-1:0] a_s2,
	output logic [COORD_FRAC_BITS-1:0] b_s2,
	output logic [RAW_ADDR_W-1:0]      raw_s2 [NUM_TAPS]
);

	localparam int F    = COORD_FRAC_BITS;
	localparam int PX_W = F + CFG_W;
	localparam int PY_W = F + 1 + CFG_W;
	localparam int VX_W = COORD_W + 2;
	localparam logic [F:0] ONE = (F+1)'(1) << F;

	logic [F-1:0]         fu;
	logic [F:0]           fv;
	logic [VX_W-1:0]      sv_ext;
	logic [CFG_W-1:0]     wm1, hm1;
	logic [PX_W-1:0]      px_c;
	logic [PY_W-1:0]      py_c;

	logic                 op_s1, fb_s1;
	logic [ADDR_IN_W-1:0] waddr_s1;
	logic [TEXEL_W-1:0]   wdata_s1;
	logic [PX_W-1:0]      px_s1;
	logic [PY_W-1:0]      py_s1;

	logic [CFG_W-1:0]     x0_raw, x0, x1, y0, y1;
	logic [CFG_W:0]       y0_raw, x0p, y0p;
	logic [RAW_ADDR_W-1:0] row0, row1;

	assign wm1 = tex_w - CFG_W'(1);
	assign hm1 = tex_h - CFG_W'(1);

	// wrap u to its fraction, clamp v to [0,1]
	always_comb begin
		fu     = req.coord_u[F-1:0];
		sv_ext = {{2{req.coord_v[COORD_W-1]}}, req.coord_v};
		if (sv_ext[VX_W-1]) begin
			fv = '0;
		end else if (sv_ext[VX_W-2:0] > (VX_W-1)'(ONE)) begin
			fv = ONE;
		end else begin
			fv = sv_ext[F:0];
		end
		px_c = PX_W'(fu) * PX_W'(wm1);
		py_c = PY_W'(fv) * PY_W'(hm1);
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			op_s1    <= req.opcode;
			waddr_s1 <= req.texel_address;
			wdata_s1 <= {req.write_red, req.write_green, req.write_blue};
			fb_s1    <= (tex_w == '0) || (tex_h == '0);
			px_s1    <= px_c;
			py_s1    <= py_c;
		end
	end

	// integer parts, edge clamps and row-major addresses
	always_comb begin
		x0_raw = px_s1[PX_W-1:F];
		y0_raw = py_s1[PY_W-1:F];
		x0     = (x0_raw > wm1) ? wm1 : x0_raw;
		y0     = (y0_raw > {1'b0, hm1}) ? hm1 : y0_raw[CFG_W-1:0];
		x0p    = {1'b0, x0} + (CFG_W+1)'(1);
		y0p    = {1'b0, y0} + (CFG_W+1)'(1);
		x1     = (x0p > {1'b0, wm1}) ? wm1 : x0p[CFG_W-1:0];
		y1     = (y0p > {1'b0, hm1}) ? hm1 : y0p[CFG_W-1:0];
		row0   = RAW_ADDR_W'(y0) * RAW_ADDR_W'(tex_w);
		row1   = RAW_ADDR_W'(y1) * RAW_ADDR_W'(tex_w);
	end

	always_ff @(posedge clk) begin
		if (en.s2) begin
			op_s2     <= op_s1;
			waddr_s2  <= waddr_s1;
			wdata_s2  <= wdata_s1;
			fb_s2     <= fb_s1;
			a_s2      <= px_s1[F-1:0];
			b_s2      <= py_s1[F-1:0];
			raw_s2[0] <= row0 + RAW_ADDR_W'(x0);
			raw_s2[1] <= row0 + RAW_ADDR_W'(x1);
			raw_s2[2] <= row1 + RAW_ADDR_W'(x0);
			raw_s2[3] <= row1 + RAW_ADDR_W'(x1);
		end
	end

endmodule

FILE: rtl/core/bts_addr_wrap.sv
module bts_addr_wrap
	import bts_pkg::*;
#(
	parameter int MAX_TEXELS      = DEF_MAX_TEXELS,
	parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS,
	localparam int AW = $clog2(MAX_TEXELS)
) (
	input  logic                       clk,
	input  stage_en_t                  en,
	input  logic                       op_s2,
	input  logic [ADDR_IN_W-1:0]       waddr_s2,
	input  logic [TEXEL_W-1:0]         wdata_s2,
	input  logic                       fb_s2,
	input  logic [COORD_FRAC_BITS-1:0] a_s2,
	input  logic [COORD_FRAC_BITS-1:0] b_s2,
	input  logic [RAW_ADDR_W-1:0]      raw_s2 [NUM_TAPS],
	output logic                       op_s4,
	output logic [ADDR_IN_W-1:0]       waddr_s4,
	output logic [TEXEL_W-1:0]         wdata_s4,
	output logic                       fb_s4,
	output logic [COORD_FRAC_BITS-1:0] a_s4,
	output logic [COORD_FRAC_BITS-1:0] b_s4,
	output logic [AW-1:0]              idx_s4 [NUM_TAPS]
);

	localparam int PW = 2 * RAW_ADDR_W;
	// floor(2^RAW_ADDR_W / MAX_TEXELS): quotient estimate is exact or one low
	localparam logic [RAW_ADDR_W-1:0] RECIP =
		RAW_ADDR_W'((64'd1 << RAW_ADDR_W) / MAX_TEXELS);
	localparam logic [RAW_ADDR_W-1:0] MODULUS = RAW_ADDR_W'(MAX_TEXELS);

	logic                       op_s3, fb_s3;
	logic [ADDR_IN_W-1:0]       waddr_s3;
	logic [TEXEL_W-1:0]         wdata_s3;
	logic [COORD_FRAC_BITS-1:0] a_s3, b_s3;
	logic [RAW_ADDR_W-1:0]      raw_s3 [NUM_TAPS];
	logic [RAW_ADDR_W-1:0]      q_s3   [NUM_TAPS];
	logic [RAW_ADDR_W-1:0]      r_s4   [NUM_TAPS];
	logic [PW-1:0]              qprod  [NUM_TAPS];
	logic [PW-1:0]              qm     [NUM_TAPS];
	logic [RAW_ADDR_W-1:0]      r_fix  [NUM_TAPS];

	always_comb begin
		for (int i = 0; i < NUM_TAPS; i++) begin
			qprod[i] = PW'(raw_s2[i]) * PW'(RECIP);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			op_s3    <= op_s2;
			waddr_s3 <= waddr_s2;
			wdata_s3 <= wdata_s2;
			fb_s3    <= fb_s2;
			a_s3     <= a_s2;
			b_s3     <= b_s2;
			for (int i = 0; i < NUM_TAPS; i++) begin
				raw_s3[i] <= raw_s2[i];
				q_s3[i]   <= qprod[i][PW-1:RAW_ADDR_W];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < NUM_TAPS; i++) begin
			qm[i] = PW'(q_s3[i]) * PW'(MODULUS);
		end
	end

	// remainder lands in [0, 2*MAX_TEXELS)
	always_ff @(posedge clk) begin
		if (en.s4) begin
			op_s4    <= op_s3;
			waddr_s4 <= waddr_s3;
			wdata_s4 <= wdata_s3;
			fb_s4    <= fb_s3;
			a_s4     <= a_s3;
			b_s4     <= b_s3;
			for (int i = 0; i < NUM_TAPS; i++) begin
				r_s4[i] <= raw_s3[i] - qm[i][RAW_ADDR_W-1:0];
			end
		end
	end

	// final correction step feeds the texel store address
	always_comb begin
		for (int i = 0; i < NUM_TAPS; i++) begin
			r_fix[i]  = (r_s4[i] >= MODULUS) ? (r_s4[i] - MODULUS) : r_s4[i];
			idx_s4[i] = r_fix[i][AW-1:0];
		end
	end

endmodule

FILE: rtl/core/bts_blend.sv
module bts_blend
	import bts_pkg::*;
#(
	parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
	input  logic                       clk,
	input  stage_en_t                  en,
	input  logic                       fb_s4,
	input  logic [COORD_FRAC_BITS-1:0] a_s4,
	input  logic [COORD_FRAC_BITS-1:0] b_s4,
	input  logic [TEXEL_W-1:0]         t00_s5,
	input  logic [TEXEL_W-1:0]         t10_s5,
	input  logic [TEXEL_W-1:0]         t01_s5,
	input  logic [TEXEL_W-1:0]         t11_s5,
	output rsp_t                       rsp_s8
);

	localparam int F     = COORD_FRAC_BITS;
	localparam int LIN_W = CHAN_W + F;
	localparam int ACC_W = CHAN_W + 2 * F;
	localparam int SHIFT = 2 * F - 8;
	localparam logic [F:0]       ONE   = (F+1)'(1) << F;
	localparam logic [ACC_W-1:0] ROUND = ACC_W'(1) << (2 * F - 9);

	logic                 fb_s5, fb_s6, fb_s7;
	logic [F-1:0]         a_s5, b_s5, b_s6;
	logic [F:0]           wa, wb;
	logic [LIN_W-1:0]     top_c [NUM_CHAN];
	logic [LIN_W-1:0]     bot_c [NUM_CHAN];
	logic [LIN_W-1:0]     top_s6 [NUM_CHAN];
	logic [LIN_W-1:0]     bot_s6 [NUM_CHAN];
	logic [ACC_W-1:0]     acc_c [NUM_CHAN];
	logic [ACC_W-1:0]     acc_s7 [NUM_CHAN];
	logic [ACC_W-1:0]     rnd [NUM_CHAN];
	logic [OUT_W-1:0]     res [NUM_CHAN];

	// side data riding along with the texel read
	always_ff @(posedge clk) begin
		if (en.s5) begin
			fb_s5 <= fb_s4;
			a_s5  <= a_s4;
			b_s5  <= b_s4;
		end
	end

	// horizontal lerp, red in the top byte
	always_comb begin
		wa = ONE - (F+1)'(a_s5);
		for (int k = 0; k < NUM_CHAN; k++) begin
			top_c[k] = LIN_W'(t00_s5[TEXEL_W-1-CHAN_W*k -: CHAN_W]) * LIN_W'(wa)
			         + LIN_W'(t10_s5[TEXEL_W-1-CHAN_W*k -: CHAN_W]) * LIN_W'(a_s5);
			bot_c[k] = LIN_W'(t01_s5[TEXEL_W-1-CHAN_W*k -: CHAN_W]) * LIN_W'(wa)
			         + LIN_W'(t11_s5[TEXEL_W-1-CHAN_W*k -: CHAN_W]) * LIN_W'(a_s5);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s6) begin
			fb_s6 <= fb_s5;
			b_s6  <= b_s5;
			for (int k = 0; k < NUM_CHAN; k++) begin
				top_s6[k] <= top_c[k];
				bot_s6[k] <= bot_c[k];
			end
		end
	end

	// vertical lerp
	always_comb begin
		wb = ONE - (F+1)'(b_s6);
		for (int k = 0; k < NUM_CHAN; k++) begin
			acc_c[k] = ACC_W'(top_s6[k]) * ACC_W'(wb) + ACC_W'(bot_s6[k]) * ACC_W'(b_s6);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s7) begin
			fb_s7 <= fb_s6;
			for (int k = 0; k < NUM_CHAN; k++) begin
				acc_s7[k] <= acc_c[k];
			end
		end
	end

	// round half up to 8 fraction bits
	always_comb begin
		for (int k = 0; k < NUM_CHAN; k++) begin
			rnd[k] = acc_s7[k] + ROUND;
			res[k] = OUT_W'(rnd[k] >> SHIFT);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s8) begin
			rsp_s8.out_red       <= fb_s7 ? FALLBACK_RG : res[0];
			rsp_s8.out_green     <= fb_s7 ? FALLBACK_RG : res[1];
			rsp_s8.out_blue      <= fb_s7 ? FALLBACK_B  : res[2];
			rsp_s8.used_fallback <= fb_s7;
		end
	end

endmodule

FILE: rtl/core/bilinear_texture_sampler.sv
// Channel   Dir  Handshake                 Beat
// req       in   req_valid / req_ready     req_t: write texel or sample at (u, v)
// rsp       out  rsp_valid / rsp_ready     rsp_t: filtered RGB, fallback flag
// cfg       in   cfg_we (no wait)          cfg_index selects width or height
//
// One beat enters per cycle when the response side keeps up. A sample is loaded
// into the response register after stages 1 to 7 and can leave at the
// next edge; a write takes effect in the texel store as it leaves stage 4
// and produces no response. The four neighbours come out of two copies of the
// store, each with two read ports, so all four are fetched together. Reset
// clears the stage valid bits and the size registers; the texel store is not
// cleared. A stalled response holds stage 8; earlier stages keep moving into
// any empty slot behind it.
module bilinear_texture_sampler
	import bts_pkg::*;
#(
	parameter int MAX_TEXELS      = DEF_MAX_TEXELS,
	parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output rsp_t                 rsp,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int F  = COORD_FRAC_BITS;
	localparam int AW = $clog2(MAX_TEXELS);

	// texture size registers
	logic [CFG_W-1:0] tex_w_q, tex_h_q;

	// pipeline control
	logic [NUM_STAGES:1] valid_q;
	logic [NUM_STAGES:1] rdy;
	logic [NUM_STAGES:1] pv;
	logic [NUM_STAGES:1] load;
	stage_en_t           en;

	// stage payload between units
	logic                  op_s2, fb_s2;
	logic [ADDR_IN_W-1:0]  waddr_s2;
	logic [TEXEL_W-1:0]    wdata_s2;
	logic [F-1:0]          a_s2, b_s2;
	logic [RAW_ADDR_W-1:0] raw_s2 [NUM_TAPS];

	logic                  op_s4, fb_s4;
	logic [ADDR_IN_W-1:0]  waddr_s4;
	logic [TEXEL_W-1:0]    wdata_s4;
	logic [F-1:0]          a_s4, b_s4;
	logic [AW-1:0]         idx_s4 [NUM_TAPS];

	logic [TEX_LIM_W-1:0]  waddr_wide;
	logic                  ram_we;
	logic [TEXEL_W-1:0]    t00_s5, t10_s5, t01_s5, t11_s5;

	// Configuration writes land immediately; unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tex_w_q <= '0;
			tex_h_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_IDX_WIDTH:  tex_w_q <= cfg_data;
				CFG_IDX_HEIGHT: tex_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Each stage accepts when empty or when the stage ahead accepts.
	// A write beat is consumed by the texel store and leaves as a bubble.
	always_comb begin
		pv[1] = req_valid;
		for (int k = 2; k <= NUM_STAGES; k++) begin
			pv[k] = valid_q[k-1];
		end
		pv[5] = valid_q[4] && (op_s4 == OP_SAMPLE);

		rdy[NUM_STAGES] = !valid_q[NUM_STAGES] || rsp_ready;
		for (int k = NUM_STAGES - 1; k >= 1; k--) begin
			rdy[k] = !valid_q[k] || rdy[k+1];
		end
		load = rdy & pv;
	end

	assign en        = stage_en_t'(load);
	assign req_ready = rdy[1];
	assign rsp_valid = valid_q[NUM_STAGES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			for (int k = 1; k <= NUM_STAGES; k++) begin
				if (rdy[k]) begin
					valid_q[k] <= pv[k];
				end
			end
		end
	end

	// Stages 1-2: coordinate wrap/clamp, scale, neighbour addresses
	bts_coord #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_coord (
		.clk      (clk),
		.en       (en),
		.req      (req),
		.tex_w    (tex_w_q),
		.tex_h    (tex_h_q),
		.op_s2    (op_s2),
		.waddr_s2 (waddr_s2),
		.wdata_s2 (wdata_s2),
		.fb_s2    (fb_s2),
		.a_s2     (a_s2),
		.b_s2     (b_s2),
		.raw_s2   (raw_s2)
	);

	// Stages 3-4: reduce addresses modulo the store depth
	bts_addr_wrap #(
		.MAX_TEXELS      (MAX_TEXELS),
		.COORD_FRAC_BITS (COORD_FRAC_BITS)
	) u_addr (
		.clk      (clk),
		.en       (en),
		.op_s2    (op_s2),
		.waddr_s2 (waddr_s2),
		.wdata_s2 (wdata_s2),
		.fb_s2    (fb_s2),
		.a_s2     (a_s2),
		.b_s2     (b_s2),
		.raw_s2   (raw_s2),
		.op_s4    (op_s4),
		.waddr_s4 (waddr_s4),
		.wdata_s4 (wdata_s4),
		.fb_s4    (fb_s4),
		.a_s4     (a_s4),
		.b_s4     (b_s4),
		.idx_s4   (idx_s4)
	);

	// Stage 5: texel store. Writes go to both copies at the same stage that
	// samples read, so a later sample always sees an earlier write. A write
	// lands on the edge where it leaves stage 4.
	// Drop writes past the end of the store.
	assign waddr_wide = TEX_LIM_W'(waddr_s4);
	assign ram_we     = valid_q[4] && rdy[5] && (op_s4 == OP_WRITE) &&
	                    (waddr_wide < TEX_LIM_W'(MAX_TEXELS));

	bts_texel_ram #(
		.DEPTH(MAX_TEXELS)
	) u_ram_row0 (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (waddr_wide[AW-1:0]),
		.wdata  (wdata_s4),
		.re     (en.s5),
		.raddr0 (idx_s4[0]),
		.raddr1 (idx_s4[1]),
		.rdata0 (t00_s5),
		.rdata1 (t10_s5)
	);

	bts_texel_ram #(
		.DEPTH(MAX_TEXELS)
	) u_ram_row1 (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (waddr_wide[AW-1:0]),
		.wdata  (wdata_s4),
		.re     (en.s5),
		.raddr0 (idx_s4[2]),
		.raddr1 (idx_s4[3]),
		.rdata0 (t01_s5),
		.rdata1 (t11_s5)
	);

	// Stages 6-8: horizontal lerp, vertical lerp, round and fallback select
	bts_blend #(
		.COORD_FRAC_BITS(COORD_FRAC_BITS)
	) u_blend (
		.clk    (clk),
		.en     (en),
		.fb_s4  (fb_s4),
		.a_s4   (a_s4),
		.b_s4   (b_s4),
		.t00_s5 (t00_s5),
		.t10_s5 (t10_s5),
		.t01_s5 (t01_s5),
		.t11_s5 (t11_s5),
		.rsp_s8 (rsp)
	);

	// An empty last stage means no stage can be blocked.
	a_ready_when_tail_empty: assert property (
		@(posedge clk) disable iff (!arst_n)
		!valid_q[NUM_STAGES] |-> req_ready
	) else $error("request side stalled with empty last stage");

	// A full pipe behind a stalled response must push back.
	a_backpressure_when_full: assert property (
		@(posedge clk) disable iff (!arst_n)
		(&valid_q && !rsp_ready) |-> !req_ready
	) else $error("request accepted into a full stalled pipeline");

	// A write beat must not continue past the texel store.
	a_write_consumed: assert property (
		@(posedge clk) disable iff (!arst_n)
		(valid_q[4] && (op_s4 == OP_WRITE) && rdy[5]) |=> !valid_q[5]
	) else $error("write beat leaked past texel store stage");

endmodule

FILE: test/bilinear_texture_sampler_tb.sv
`timescale 1ns / 100ps

module bilinear_texture_sampler_tb;
	import bts_pkg::*;

	localparam int FRAC        = DEF_COORD_FRAC_BITS;
	localparam longint unsigned ONE = 64'd1 << FRAC;
	localparam int SETTLE      = 16;
	localparam int HOLD_CYCLES = 80;
	localparam int QUIET_LIMIT = 2000;
	localparam int PHASES      = 9;
	localparam int PHASE_ITEMS = 32;

	localparam rsp_t FALLBACK = '{FALLBACK_RG, FALLBACK_RG, FALLBACK_B, 1'b1};
	localparam rsp_t NO_COLOR = '0;

	typedef enum {STEP_SIZE, STEP_WRITE, STEP_SAMPLE} step_e;

	// One row of the directed plan. arg0/arg1 carry width/height, the texel
	// address, or u/v depending on the step.
	typedef struct {
		step_e              step;
		int                 arg0;
		int                 arg1;
		bit [TEXEL_W-1:0]   rgb;
		bit                 typed;
		rsp_t               color;
	} row_t;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_ready;
	req_t                 req       = '0;
	logic                 rsp_valid;
	logic                 rsp_ready = 1'b0;
	rsp_t                 rsp;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_IDX_WIDTH;
	logic [CFG_W-1:0]     cfg_data  = '0;

	// Shadow of the block: texel store, which texels hold data, and sizes
	bit [TEXEL_W-1:0] texels [DEF_MAX_TEXELS];
	bit               loaded [DEF_MAX_TEXELS];
	bit [CFG_W-1:0]   tex_w = '0;
	bit [CFG_W-1:0]   tex_h = '0;

	rsp_t        colors_due [$];
	row_t        plan [$];
	int          failures     = 0;
	int unsigned send_gap_max = 10;
	int unsigned rsp_gap_max  = 10;
	bit          hold_rsp     = 1'b0;
	int          quiet        = 0;

	bilinear_texture_sampler dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Row-major index, wrapped to the store depth like the block does
	function automatic bit [ADDR_IN_W-1:0] texel_index(input bit [CFG_W-1:0] x,
			input bit [CFG_W-1:0] y);
		return ADDR_IN_W'(32'(y) * 32'(tex_w) + 32'(x));
	endfunction

	// Work out the four neighbour addresses and the blend weights for (u, v).
	// u keeps only its fraction, v is pinned to [0, 1].
	function automatic void tap_plan(input logic [COORD_W-1:0] u,
			input logic [COORD_W-1:0] v, output bit [3:0][ADDR_IN_W-1:0] taps,
			output bit [FRAC:0] wa, output bit [FRAC:0] wb);
		bit [FRAC-1:0]  fu;
		bit [FRAC:0]    fv;
		bit [31:0]      px, py;
		bit [CFG_W-1:0] x0, y0, x1, y1, wmax, hmax;
		int             sv;
		wmax = tex_w - 1'b1;
		hmax = tex_h - 1'b1;
		fu = u[FRAC-1:0];
		sv = $signed(v);
		if (sv < 0) begin
			fv = '0;
		end else if (sv > int'(ONE)) begin
			fv = (FRAC+1)'(ONE);
		end else begin
			fv = (FRAC+1)'(sv);
		end
		px = 32'(fu) * 32'(wmax);
		py = 32'(fv) * 32'(hmax);
		x0 = CFG_W'(px >> FRAC);
		y0 = CFG_W'(py >> FRAC);
		wa = {1'b0, px[FRAC-1:0]};
		wb = {1'b0, py[FRAC-1:0]};
		if (x0 > wmax) x0 = wmax;
		if (y0 > hmax) y0 = hmax;
		// neighbours stop at the far edge
		x1 = (x0 == wmax) ? wmax : x0 + 1'b1;
		y1 = (y0 == hmax) ? hmax : y0 + 1'b1;
		taps[0] = texel_index(x0, y0);
		taps[1] = texel_index(x1, y0);
		taps[2] = texel_index(x0, y1);
		taps[3] = texel_index(x1, y1);
	endfunction

	// Expected filtered color for a sample at (u, v) under the current sizes
	function automatic rsp_t bilinear_blend(input logic [COORD_W-1:0] u,
			input logic [COORD_W-1:0] v);
		bit [3:0][ADDR_IN_W-1:0] taps;
		bit [FRAC:0]             wa, wb;
		bit [7:0]                c [4];
		bit [OUT_W-1:0]          ch [3];
		longint unsigned         top, bot, acc;
		if (tex_w == 0 || tex_h == 0) return FALLBACK;
		tap_plan(u, v, taps, wa, wb);
		for (int k = 0; k < NUM_CHAN; k++) begin
			// red sits in bits 23:16, blue in 7:0
			for (int i = 0; i < NUM_TAPS; i++)
				c[i] = 8'(texels[taps[i]] >> (16 - 8 * k));
			top = 64'(c[0]) * (ONE - 64'(wa)) + 64'(c[1]) * 64'(wa);
			bot = 64'(c[2]) * (ONE - 64'(wa)) + 64'(c[3]) * 64'(wa);
			acc = top * (ONE - 64'(wb)) + bot * 64'(wb);
			// round half up, keep 8 fraction bits
			acc = (acc + (64'd1 << (2 * FRAC - 9))) >> (2 * FRAC - 8);
			ch[k] = OUT_W'(acc);
		end
		return '{ch[0], ch[1], ch[2], 1'b0};
	endfunction

	function automatic void add_row(input step_e step, input int arg0, input int arg1,
			input bit [TEXEL_W-1:0] rgb, input bit typed, input rsp_t color);
		row_t r;
		r = '{step, arg0, arg1, rgb, typed, color};
		plan.push_back(r);
	endfunction

	// Present one beat after a random gap and hold it until accepted.
	// Valid stays high on return so a back-to-back beat needs no extra edge.
	task automatic offer(input req_t beat);
		int unsigned gap;
		gap = $urandom_range(0, send_gap_max);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= beat;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
	endtask

	task automatic send_write(input bit [ADDR_IN_W-1:0] addr,
			input bit [TEXEL_W-1:0] rgb);
		req_t      beat;
		bit [95:0] noise;
		// unused coordinate fields carry noise
		noise = {$urandom, $urandom, $urandom};
		beat = noise[$bits(req_t)-1:0];
		beat.opcode        = OP_WRITE;
		beat.texel_address = addr;
		{beat.write_red, beat.write_green, beat.write_blue} = rgb;
		offer(beat);
		texels[addr] = rgb;
		loaded[addr] = 1'b1;
	endtask

	// Sample at (u, v). Any neighbour that was never written gets a random
	// texel first, so the block never reads an empty store entry.
	task automatic send_sample(input logic [COORD_W-1:0] u, input logic [COORD_W-1:0] v,
			input bit typed, input rsp_t color);
		bit [3:0][ADDR_IN_W-1:0] taps;
		bit [FRAC:0]             wa, wb;
		req_t                    beat;
		bit [95:0]               noise;
		if (tex_w != 0 && tex_h != 0) begin
			tap_plan(u, v, taps, wa, wb);
			for (int i = 0; i < NUM_TAPS; i++)
				if (!loaded[taps[i]]) send_write(taps[i], TEXEL_W'($urandom));
		end
		noise = {$urandom, $urandom, $urandom};
		beat = noise[$bits(req_t)-1:0];
		beat.opcode  = OP_SAMPLE;
		beat.coord_u = u;
		beat.coord_v = v;
		offer(beat);
		colors_due.push_back(typed ? color : bilinear_blend(u, v));
	endtask

	// Drop valid and wait until every sample in flight has come back
	task automatic drain_colors();
		req_valid <= 1'b0;
		while (colors_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Load both size registers while the block is idle
	task automatic set_size(input bit [CFG_W-1:0] w, input bit [CFG_W-1:0] h);
		drain_colors();
		cfg_we    <= 1'b1;
		cfg_index <= CFG_IDX_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= CFG_IDX_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
		tex_w = w;
		tex_h = h;
	endtask

	// Response side: random ready gaps, one long hold-off on request, and a
	// field-by-field compare against the oldest expected color.
	initial begin
		int unsigned gap;
		int unsigned beats;
		rsp_t        want;
		rsp_t        got;
		beats = 0;
		wait (arst_n);
		forever begin
			if (hold_rsp) begin
				hold_rsp = 1'b0;
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			if (beats % 32 == 0) rsp_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
			gap = $urandom_range(0, rsp_gap_max);
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
			beats++;
			got = rsp;
			if (colors_due.size() == 0) begin
				$error("unexpected color beat: red %0d green %0d blue %0d fallback %0d",
					got.out_red, got.out_green, got.out_blue, got.used_fallback);
				failures++;
			end else begin
				want = colors_due.pop_front();
				if (got.out_red !== want.out_red) begin
					$error("out_red: expected %0d, got %0d", want.out_red, got.out_red);
					failures++;
				end
				if (got.out_green !== want.out_green) begin
					$error("out_green: expected %0d, got %0d", want.out_green, got.out_green);
					failures++;
				end
				if (got.out_blue !== want.out_blue) begin
					$error("out_blue: expected %0d, got %0d", want.out_blue, got.out_blue);
					failures++;
				end
				if (got.used_fallback !== want.used_fallback) begin
					$error("used_fallback: expected %0d, got %0d",
						want.used_fallback, got.used_fallback);
					failures++;
				end
			end
		end
	end

	// Watchdog: end the run if neither channel moves a beat for too long
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet = 0;
		end else begin
			quiet = quiet + 1;
		end
		if (quiet >= QUIET_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		bit [COORD_W-1:0]   u, v;
		bit [ADDR_IN_W-1:0] addr;
		int                 area;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed plan. Sizes reset to zero, so the first samples fall back.
		add_row(STEP_SAMPLE, 0, 0, '0, 1'b1, FALLBACK);
		add_row(STEP_SAMPLE, -8388608, 8388607, '0, 1'b1, FALLBACK);
		// either size at zero means no texture
		add_row(STEP_SIZE, 0, 7, '0, 1'b0, NO_COLOR);
		add_row(STEP_SAMPLE, 32'h8000, 32'h8000, '0, 1'b1, FALLBACK);
		add_row(STEP_SIZE, 7, 0, '0, 1'b0, NO_COLOR);
		add_row(STEP_SAMPLE, 8388607, -8388608, '0, 1'b1, FALLBACK);
		add_row(STEP_WRITE, 0, 0, 24'hFF0080, 1'b0, NO_COLOR);
		add_row(STEP_WRITE, 16'hFFFF, 0, 24'h00FF7F, 1'b0, NO_COLOR);
		// a single texel: every coordinate lands on texel 0
		add_row(STEP_SIZE, 1, 1, '0, 1'b0, NO_COLOR);
		add_row(STEP_SAMPLE, 0, 0, '0, 1'b1, '{16'hFF00, 16'h0000, 16'h8000, 1'b0});
		add_row(STEP_SAMPLE, -8388608, -8388608, '0, 1'b1,
			'{16'hFF00, 16'h0000, 16'h8000, 1'b0});
		add_row(STEP_SAMPLE, 8388607, 8388607, '0, 1'b1,
			'{16'hFF00, 16'h0000, 16'h8000, 1'b0});
		add_row(STEP_SIZE, 2, 2, '0, 1'b0, NO_COLOR);
		add_row(STEP_WRITE, 1, 0, 24'h00FF00, 1'b0, NO_COLOR);
		add_row(STEP_WRITE, 2, 0, 24'h0000FF, 1'b0, NO_COLOR);
		add_row(STEP_WRITE, 3, 0, 24'hFFFFFF, 1'b0, NO_COLOR);
		add_row(STEP_SAMPLE, 0, 0, '0, 1'b1, '{16'hFF00, 16'h0000, 16'h8000, 1'b0});
		add_row(STEP_SAMPLE, 32'h8000, 32'h8000, '0, 1'b0, NO_COLOR);
		add_row(STEP_SAMPLE, 32'hFFFF, 32'h10000, '0, 1'b0, NO_COLOR);
		// u = 1.0 wraps to 0, v far above 1 clamps to the last row: texel 2
		add_row(STEP_SAMPLE, 32'h10000, 8388607, '0, 1'b1,
			'{16'h0000, 16'h0000, 16'hFF00, 1'b0});
		// sizes past the nominal range: addresses wrap in the store
		add_row(STEP_SIZE, 2047, 2047, '0, 1'b0, NO_COLOR);
		add_row(STEP_SAMPLE, 32'hFFFF, 32'hFFFF, '0, 1'b0, NO_COLOR);
		add_row(STEP_SIZE, 1024, 1024, '0, 1'b0, NO_COLOR);
		add_row(STEP_SAMPLE, 32'h8000, 32'h10000, '0, 1'b0, NO_COLOR);

		foreach (plan[i]) begin
			case (plan[i].step)
				STEP_SIZE: begin
					set_size(CFG_W'(plan[i].arg0), CFG_W'(plan[i].arg1));
				end
				STEP_WRITE: begin
					send_write(ADDR_IN_W'(plan[i].arg0), plan[i].rgb);
				end
				default: begin
					send_sample(COORD_W'(plan[i].arg0), COORD_W'(plan[i].arg1),
						plan[i].typed, plan[i].color);
				end
			endcase
		end

		// Random phases, each under its own texture size
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				3: begin
					set_size(1024, 1);
				end
				5: begin
					set_size(1, 1024);
				end
				7: begin
					set_size(0, CFG_W'($urandom_range(1, 2047)));
				end
				8: begin
					set_size(CFG_W'($urandom_range(1025, 2047)), CFG_W'($urandom_range(1, 8)));
				end
				default: begin
					set_size(CFG_W'($urandom_range(1, 24)), CFG_W'($urandom_range(1, 24)));
				end
			endcase
			send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 10;
			// stall the response side for a long stretch while beats keep coming
			if (phase == 1) begin
				send_gap_max = 0;
				hold_rsp = 1'b1;
			end
			area = int'(tex_w) * int'(tex_h);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// pause the sender once until the pipeline is empty
				if (phase == 4 && n == PHASE_ITEMS / 2) drain_colors();
				if ($urandom_range(0, 9) < 3) begin
					if (area == 0 || $urandom_range(0, 1) == 0) begin
						addr = ADDR_IN_W'($urandom);
					end else begin
						addr = ADDR_IN_W'($urandom_range(0, area - 1));
					end
					send_write(addr, TEXEL_W'($urandom));
				end else begin
					case ($urandom_range(0, 3))
						0: u = COORD_W'($urandom);
						1: u = COORD_W'($urandom_range(0, 32'hFFFF));
						2: u = ($urandom_range(0, 1) == 0) ? COORD_W'(32'hFFFF) : '1;
						default: u = COORD_W'({$urandom_range(0, 255), 16'h0000})
							| COORD_W'($urandom_range(0, 15));
					endcase
					case ($urandom_range(0, 3))
						0: v = COORD_W'($urandom);
						1, 2: v = COORD_W'($urandom_range(0, 32'h10000));
						default: begin
							case ($urandom_range(0, 3))
								0: v = COORD_W'(32'h10000);
								1: v = COORD_W'(32'h10001);
								2: v = '1;
								default: v = COORD_W'(32'hFFFF);
							endcase
						end
					endcase
					send_sample(u, v, 1'b0, NO_COLOR);
				end
			end
		end

		drain_colors();
		if (failures == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
